FILE: rtl/core/distance_itd_delay_pair_unit_assert.svh
// Assertion helpers for the distance/interaural delay pair unit.
`ifndef DISTANCE_ITD_DELAY_PAIR_UNIT_ASSERT_SVH
`define DISTANCE_ITD_DELAY_PAIR_UNIT_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define DIP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dip check failed");

// Check that cons holds in the cycle after ante.
`define DIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dip check failed");

`endif

FILE: rtl/core/dip_pkg.sv
package dip_pkg;

  localparam int unsigned MAIN_DEPTH_DEF = 4096;
  localparam int unsigned EAR_DEPTH_DEF  = 64;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned OFFSET_W   = 7;
  localparam int unsigned TAP_SUM_W  = DIST_W + 1;
  localparam int unsigned PROD_W     = SAMPLE_W + GAIN_W;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SHIFTED_W  = PROD_W - FRAC_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EAR_OFFSET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_GAIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBINED_MODE = 2'd3;

  localparam logic signed [GAIN_W-1:0]    GAIN_RESET = 20'sd65536;
  localparam logic signed [PROD_W-1:0]    ROUND_BIAS = 44'sd32768;
  localparam logic signed [SHIFTED_W-1:0] SAT_MAX    = 28'sd8388607;
  localparam logic signed [SHIFTED_W-1:0] SAT_MIN    = -28'sd8388608;

  typedef struct packed {
    logic [DIST_W-1:0]          base_delay;
    logic signed [OFFSET_W-1:0] ear_offset;
    logic signed [GAIN_W-1:0]   path_gain;
    logic                       combined_mode;
  } cfg_t;

  function automatic logic [OFFSET_W-1:0] offset_mag(logic signed [OFFSET_W-1:0] off);
    return off[OFFSET_W-1] ? OFFSET_W'(-off) : OFFSET_W'(off);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] scale_sat(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0]    biased;
    logic signed [SHIFTED_W-1:0] r;
    biased = p + ROUND_BIAS;
    r      = biased[PROD_W-1:FRAC_W];
    if (r > SAT_MAX) begin
      return SAT_MAX[SAMPLE_W-1:0];
    end else if (r < SAT_MIN) begin
      return SAT_MIN[SAMPLE_W-1:0];
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/core/distance_itd_delay_pair_unit.sv
// Each input is registered in the main line, gain and ear line in turn.
// One sample per cycle unless stalled; output register holds under stall.
// Stages: main ring memory read, gain multiply, ear ring memory read.
// Reset: clears control state and restores register defaults at once.
// Unwritten ring entries read as zero by fill count; no clearing pass.
module distance_itd_delay_pair_unit import dip_pkg::*; #(
  parameter int unsigned MAIN_DEPTH = MAIN_DEPTH_DEF,
  parameter int unsigned EAR_DEPTH  = EAR_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SAMPLE_W-1:0]   sample_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_W-1:0]   first_ear_out_o,
  output logic signed [SAMPLE_W-1:0]   second_ear_out_o
);

  cfg_t cfg_q, cfg_d;

  logic                       v1, v2, v3;
  logic                       en1, en2, en3;
  logic signed [SAMPLE_W-1:0] s1_near, s1_far, s2_near, s2_far;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BASE_DELAY:    cfg_d.base_delay    = cfg_data_i[DIST_W-1:0];
        CFG_EAR_OFFSET:    cfg_d.ear_offset    = cfg_data_i[OFFSET_W-1:0];
        CFG_PATH_GAIN:     cfg_d.path_gain     = cfg_data_i[GAIN_W-1:0];
        CFG_COMBINED_MODE: cfg_d.combined_mode = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_delay    <= '0;
      cfg_q.ear_offset    <= '0;
      cfg_q.path_gain     <= GAIN_RESET;
      cfg_q.combined_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  assign en3        = !v3 || out_ready_i;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_ready_o = en1;

  dip_main_line #(
    .MAIN_DEPTH(MAIN_DEPTH)
  ) u_main (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_fire_i(in_valid_i && en1),
    .sample_i (sample_in_i),
    .adv_i    (en1),
    .valid_o  (v1),
    .near_o   (s1_near),
    .far_o    (s1_far)
  );

  dip_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .gain_i (cfg_q.path_gain),
    .valid_i(v1),
    .near_i (s1_near),
    .far_i  (s1_far),
    .adv_i  (en2),
    .valid_o(v2),
    .near_o (s2_near),
    .far_o  (s2_far)
  );

  dip_ear_line #(
    .EAR_DEPTH(EAR_DEPTH)
  ) u_ear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (v2),
    .dist_i  (s2_near),
    .far_i   (s2_far),
    .adv_i   (en3),
    .valid_o (v3),
    .first_o (first_ear_out_o),
    .second_o(second_ear_out_o)
  );

  assign out_valid_o = v3;

endmodule

FILE: rtl/core/dip_main_line.sv
module dip_main_line import dip_pkg::*; #(
  parameter int unsigned MAIN_DEPTH = MAIN_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       in_fire_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       adv_i,
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] near_o,
  output logic signed [SAMPLE_W-1:0] far_o
);

  localparam int unsigned AW = $clog2(MAIN_DEPTH);
  localparam int unsigned CW = (AW > TAP_SUM_W) ? AW : TAP_SUM_W;
  localparam logic [CW-1:0] MAX_DLY = CW'(MAIN_DEPTH - 1);
  localparam logic [AW-1:0] LAST_POS = AW'(MAIN_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(MAIN_DEPTH);

  function automatic logic [AW-1:0] clamp_dly(logic [CW-1:0] d);
    return (d > MAX_DLY) ? MAX_DLY[AW-1:0] : d[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] tap_addr(logic [AW-1:0] wp, logic [AW-1:0] d);
    logic [AW:0] diff;
    diff = {1'b0, wp} - {1'b0, d};
    if (diff[AW]) begin
      diff = diff + DEPTH_X;
    end
    return diff[AW-1:0];
  endfunction

  logic signed [SAMPLE_W-1:0] mem_q [MAIN_DEPTH];
  logic [AW-1:0]              wp_q, wp_d;
  logic [AW:0]                cnt_q, cnt_d;
  logic                       valid_q;
  logic signed [SAMPLE_W-1:0] x_q, rd_near_q, rd_far_q;
  logic                       near_ok_q, near_fwd_q, far_ok_q, far_fwd_q;

  logic [OFFSET_W-1:0] mag;
  logic [AW-1:0]       near_dly, far_dly, near_addr, far_addr;

  assign mag       = offset_mag(cfg_i.ear_offset);
  assign near_dly  = clamp_dly(CW'(cfg_i.base_delay));
  assign far_dly   = clamp_dly(CW'(cfg_i.base_delay) + CW'(mag));
  assign near_addr = tap_addr(wp_q, near_dly);
  assign far_addr  = tap_addr(wp_q, far_dly);

  assign wp_d  = (wp_q == LAST_POS) ? '0 : wp_q + 1'b1;
  assign cnt_d = (cnt_q == DEPTH_X) ? cnt_q : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_fire_i) begin
        wp_q  <= wp_d;
        cnt_q <= cnt_d;
      end
      if (adv_i) begin
        valid_q <= in_fire_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      mem_q[wp_q] <= sample_i;
    end
    if (adv_i) begin
      rd_near_q <= mem_q[near_addr];
      rd_far_q  <= mem_q[far_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q        <= sample_i;
      near_ok_q  <= ({1'b0, near_dly} <= cnt_q);
      near_fwd_q <= (near_dly == '0);
      far_ok_q   <= ({1'b0, far_dly} <= cnt_q);
      far_fwd_q  <= (far_dly == '0);
    end
  end

  assign valid_o = valid_q;
  assign near_o  = near_fwd_q ? x_q : (near_ok_q ? rd_near_q : '0);
  assign far_o   = far_fwd_q ? x_q : (far_ok_q ? rd_far_q : '0);

endmodule

FILE: rtl/core/dip_gain.sv
module dip_gain import dip_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [GAIN_W-1:0]   gain_i,
  input  logic                       valid_i,
  input  logic signed [SAMPLE_W-1:0] near_i,
  input  logic signed [SAMPLE_W-1:0] far_i,
  input  logic                       adv_i,
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] near_o,
  output logic signed [SAMPLE_W-1:0] far_o
);

  logic                     valid_q;
  logic signed [PROD_W-1:0] p_near_q, p_near_d, p_far_q, p_far_d;

  assign p_near_d = PROD_W'(near_i) * PROD_W'(gain_i);
  assign p_far_d  = PROD_W'(far_i) * PROD_W'(gain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_near_q <= p_near_d;
      p_far_q  <= p_far_d;
    end
  end

  assign valid_o = valid_q;
  assign near_o  = scale_sat(p_near_q);
  assign far_o   = scale_sat(p_far_q);

endmodule

FILE: rtl/core/dip_ear_line.sv
module dip_ear_line import dip_pkg::*; #(
  parameter int unsigned EAR_DEPTH = EAR_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       valid_i,
  input  logic signed [SAMPLE_W-1:0] dist_i,
  input  logic signed [SAMPLE_W-1:0] far_i,
  input  logic                       adv_i,
  output logic                       valid_o,
  output logic signed [SAMPLE_W-1:0] first_o,
  output logic signed [SAMPLE_W-1:0] second_o
);

  localparam int unsigned EW = $clog2(EAR_DEPTH);
  localparam int unsigned EC = (EW > OFFSET_W) ? EW : OFFSET_W;
  localparam logic [EC-1:0] MAX_DLY = EC'(EAR_DEPTH - 1);
  localparam logic [EW-1:0] LAST_POS = EW'(EAR_DEPTH - 1);
  localparam logic [EW:0]   DEPTH_X = (EW + 1)'(EAR_DEPTH);

  logic signed [SAMPLE_W-1:0] mem_q [EAR_DEPTH];
  logic [EW-1:0]              wp_q, wp_d;
  logic [EW:0]                cnt_q, cnt_d;
  logic                       valid_q;
  logic signed [SAMPLE_W-1:0] dist_q, far_q, rd_q;
  logic                       ok_q, fwd_q, comb_q, neg_q;

  logic [EC-1:0]              mag_x;
  logic [EW-1:0]              dly, rd_addr;
  logic [EW:0]                diff;
  logic                       wr;
  logic signed [SAMPLE_W-1:0] late, delayed;

  assign mag_x = EC'(offset_mag(cfg_i.ear_offset));
  assign dly   = (mag_x > MAX_DLY) ? MAX_DLY[EW-1:0] : mag_x[EW-1:0];

  always_comb begin
    diff = {1'b0, wp_q} - {1'b0, dly};
    if (diff[EW]) begin
      diff = diff + DEPTH_X;
    end
  end
  assign rd_addr = diff[EW-1:0];

  assign wr    = adv_i && valid_i && !cfg_i.combined_mode;
  assign wp_d  = (wp_q == LAST_POS) ? '0 : wp_q + 1'b1;
  assign cnt_d = (cnt_q == DEPTH_X) ? cnt_q : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr) begin
        wp_q  <= wp_d;
        cnt_q <= cnt_d;
      end
      if (adv_i) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= dist_i;
    end
    if (adv_i) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dist_q <= dist_i;
      far_q  <= far_i;
      ok_q   <= ({1'b0, dly} <= cnt_q);
      fwd_q  <= (dly == '0);
      comb_q <= cfg_i.combined_mode;
      neg_q  <= cfg_i.ear_offset[OFFSET_W-1];
    end
  end

  assign late     = fwd_q ? dist_q : (ok_q ? rd_q : '0);
  assign delayed  = comb_q ? far_q : late;
  assign valid_o  = valid_q;
  assign first_o  = neg_q ? dist_q : delayed;
  assign second_o = neg_q ? delayed : dist_q;

endmodule

FILE: rtl/core/dip_checker.sv
`include "distance_itd_delay_pair_unit_assert.svh"

module dip_checker import dip_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_ready_o,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] first_ear_out_o,
  input logic signed [SAMPLE_W-1:0] second_ear_out_o
);

  logic                  stall;
  logic [2*SAMPLE_W-1:0] ear_pair;

  assign stall    = out_valid_o && !out_ready_i;
  assign ear_pair = {first_ear_out_o, second_ear_out_o};

  `DIP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall, out_valid_o && $stable(ear_pair))
  `DIP_ASSERT(a_in_block_needs_stall, clk_i, rst_ni, !in_ready_o |-> stall)
  `DIP_ASSERT(a_in_open_when_out_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `DIP_ASSERT(a_cfg_always_open, clk_i, rst_ni, cfg_ready_o)

endmodule

bind distance_itd_delay_pair_unit dip_checker u_dip_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_ready_o     (cfg_ready_o),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .first_ear_out_o (first_ear_out_o),
  .second_ear_out_o(second_ear_out_o)
);

FILE: test/tb_distance_itd_delay_pair_unit.sv
`timescale 1ns / 100ps

module tb_distance_itd_delay_pair_unit;
  import dip_pkg::*;

  localparam int MAIN_N     = MAIN_DEPTH_DEF;
  localparam int EAR_N      = EAR_DEPTH_DEF;
  localparam int SETTLE     = 6;
  localparam int QUIET_MAX  = 2000;
  localparam int SHOW_MAX   = 30;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first;
    logic signed [SAMPLE_W-1:0] second;
  } ear_pair_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = CFG_BASE_DELAY;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] first_ear_out_o;
  logic signed [SAMPLE_W-1:0] second_ear_out_o;

  // predictor state
  logic signed [SAMPLE_W-1:0] main_mem [MAIN_N];
  logic signed [SAMPLE_W-1:0] ear_mem [EAR_N];
  int                         main_wr;
  int                         ear_wr;
  cfg_t                       model_cfg;

  ear_pair_t expected_ears [$];
  bit        steady;
  int        mismatches;
  int        n_samples;
  int        n_results;
  int        n_writes;
  int        quiet;

  distance_itd_delay_pair_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_in_i     (sample_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .first_ear_out_o (first_ear_out_o),
    .second_ear_out_o(second_ear_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [SAMPLE_W-1:0] apply_gain(logic signed [SAMPLE_W-1:0] s,
                                                            longint g);
    longint p;
    longint r;
    p = longint'(s) * g;
    r = (p + 32768) >>> FRAC_W;
    if (r > 8388607) begin
      r = 8388607;
    end else if (r < -8388608) begin
      r = -8388608;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] main_at(int d);
    if (d > MAIN_N - 1) begin
      d = MAIN_N - 1;
    end
    return main_mem[(main_wr + MAIN_N - d) % MAIN_N];
  endfunction

  function automatic ear_pair_t predict_ears(logic signed [SAMPLE_W-1:0] s);
    ear_pair_t                  res;
    int                         off;
    int                         mag;
    int                         base;
    int                         late_d;
    longint                     g;
    logic signed [SAMPLE_W-1:0] near_v;
    logic signed [SAMPLE_W-1:0] far_v;
    off  = $signed(model_cfg.ear_offset);
    mag  = (off < 0) ? -off : off;
    base = model_cfg.base_delay;
    g    = $signed(model_cfg.path_gain);
    main_mem[main_wr] = s;
    if (model_cfg.combined_mode) begin
      near_v = apply_gain(main_at(base), g);
      far_v  = apply_gain(main_at(base + mag), g);
    end else begin
      near_v = apply_gain(main_at(base), g);
      ear_mem[ear_wr] = near_v;
      late_d = (mag > EAR_N - 1) ? EAR_N - 1 : mag;
      far_v  = ear_mem[(ear_wr + EAR_N - late_d) % EAR_N];
      ear_wr = (ear_wr + 1) % EAR_N;
    end
    main_wr    = (main_wr + 1) % MAIN_N;
    res.first  = (off >= 0) ? far_v : near_v;
    res.second = (off >= 0) ? near_v : far_v;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: begin
        v = $urandom_range(0, 32);
        return SAMPLE_W'(v - 16);
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_ears.push_back(predict_ears(s));
    n_samples++;
  endtask

  task automatic wait_drained();
    while (expected_ears.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] data;
    junk = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
    case (idx)
      CFG_BASE_DELAY:    data = {junk[CFG_DATA_W-1:DIST_W], value[DIST_W-1:0]};
      CFG_EAR_OFFSET:    data = {junk[CFG_DATA_W-1:OFFSET_W], value[OFFSET_W-1:0]};
      CFG_COMBINED_MODE: data = {junk[CFG_DATA_W-1:1], value[0]};
      default:           data = value;
    endcase
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_BASE_DELAY:    model_cfg.base_delay    = data[DIST_W-1:0];
      CFG_EAR_OFFSET:    model_cfg.ear_offset    = data[OFFSET_W-1:0];
      CFG_PATH_GAIN:     model_cfg.path_gain     = data[GAIN_W-1:0];
      CFG_COMBINED_MODE: model_cfg.combined_mode = data[0];
      default: ;
    endcase
    n_writes++;
  endtask

  // drop the stream, wait for the pipe to empty, then rewrite every register
  task automatic apply_settings(input logic [DIST_W-1:0] delay,
                                input logic signed [OFFSET_W-1:0] offset,
                                input logic signed [GAIN_W-1:0] gain,
                                input logic mode);
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(CFG_BASE_DELAY, CFG_DATA_W'(delay));
    write_reg(CFG_EAR_OFFSET, CFG_DATA_W'(offset));
    write_reg(CFG_PATH_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_COMBINED_MODE, CFG_DATA_W'(mode));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);
    push_sample(24'h000000);
    push_sample(24'hFFFFFF);
    push_sample(24'h000001);
    push_sample(24'h555555);
  endtask

  task automatic test_gain_saturation();
    apply_settings(12'd0, 7'sd0, 20'sh7FFFF, 1'b0);
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);
    push_sample(24'h000001);
    push_sample(24'hFFFFFF);
    apply_settings(12'd0, 7'sd0, 20'sh80000, 1'b0);
    push_sample(24'h800000);
    push_sample(24'h7FFFFF);
  endtask

  task automatic test_rounding();
    apply_settings(12'd0, 7'sd0, 20'sd32768, 1'b0);
    push_sample(24'h000001);
    push_sample(24'hFFFFFF);
    push_sample(24'h000003);
    push_sample(24'hFFFFFD);
  endtask

  task automatic test_delay_extremes();
    apply_settings(12'd2, -7'sd64, 20'sd65536, 1'b0);
    push_sample(24'h123456);
    push_sample(24'h800000);
    push_sample(24'h7FFFFF);
    apply_settings(12'd5, 7'sd63, 20'sd65536, 1'b1);
    push_sample(24'h0ABCDE);
    push_sample(24'hF00001);
    push_sample(24'h000007);
    apply_settings(12'd4095, -7'sd64, 20'sd65536, 1'b1);
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);
    push_sample(24'h000011);
  endtask

  task automatic test_random_settings();
    logic [DIST_W-1:0]          delay;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [GAIN_W-1:0]   gain;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: delay = '0;
        1: delay = 12'd4095;
        2: delay = DIST_W'($urandom_range(0, 80));
        default: delay = DIST_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: offset = -7'sd64;
        1: offset = 7'sd63;
        2: offset = '0;
        default: offset = OFFSET_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: gain = 20'sh7FFFF;
        1: gain = 20'sh80000;
        2: gain = 20'sd65536;
        default: gain = GAIN_W'($urandom);
      endcase
      apply_settings(delay, offset, gain, 1'($urandom_range(0, 1)));
      repeat (150) push_sample(rand_sample());
    end
  endtask

  // long back-to-back stream with both sides always ready
  task automatic test_steady_stream();
    apply_settings(12'd1500, -7'sd63, 20'sd70000, 1'b1);
    steady = 1'b1;
    repeat (750) push_sample(rand_sample());
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    ear_pair_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_ears.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) begin
            $display("%0t: unexpected result, expected none, actual %0d / %0d",
                     $time, first_ear_out_o, second_ear_out_o);
          end
        end else begin
          want = expected_ears.pop_front();
          if (first_ear_out_o !== want.first) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
              $display("%0t: first_ear_out expected %0d actual %0d",
                       $time, want.first, first_ear_out_o);
            end
          end
          if (second_ear_out_o !== want.second) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
              $display("%0t: second_ear_out expected %0d actual %0d",
                       $time, want.second, second_ear_out_o);
            end
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_MAX) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
        $display("TEST FAILED");
        $finish;
      end
      out_ready_i <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  initial begin
    foreach (main_mem[i]) main_mem[i] = '0;
    foreach (ear_mem[i]) ear_mem[i] = '0;
    main_wr                  = 0;
    ear_wr                   = 0;
    model_cfg.base_delay     = '0;
    model_cfg.ear_offset     = '0;
    model_cfg.path_gain      = GAIN_RESET;
    model_cfg.combined_mode  = 1'b0;
    steady                   = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_gain_saturation();
    test_rounding();
    test_delay_extremes();
    test_random_settings();
    test_steady_stream();

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d ear pairs, made %0d register writes",
             n_samples, n_results, n_writes);
    $display("Covered reset defaults, gain and delay extremes, both modes and a line wrap");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/dip_pkg.sv
rtl/core/dip_main_line.sv
rtl/core/dip_gain.sv
rtl/core/dip_ear_line.sv
rtl/core/distance_itd_delay_pair_unit.sv
rtl/core/dip_checker.sv
test/tb_distance_itd_delay_pair_unit.sv
